// ===== design/clld_pkg.sv =====
// ----------------------------------------------------------------------------
// clld_pkg
// Shared types and constants of the code length list decoder.
// ----------------------------------------------------------------------------
package clld_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam logic [5:0] SIZE_LIMIT = 6'((MAX_ENTRIES < 32) ? MAX_ENTRIES : 32);

    localparam logic [2:0] MAX_FIELD_BITS = 3'd5;
    localparam logic [2:0] LEN_BITS       = 3'd3;
    localparam logic [2:0] ZRUN_BITS      = 3'd2;
    localparam logic [2:0] LEN_ESCAPE     = 3'd7;
    localparam logic [3:0] UNARY_MAX      = 4'd13;

    localparam logic [1:0] REG_TABLE_SIZE    = 2'd0;
    localparam logic [1:0] REG_COUNT_BITS    = 2'd1;
    localparam logic [1:0] REG_SPECIAL_INDEX = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_COUNT = 7'b0000010,
        PH_CODE  = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_UNARY = 7'b0010000,
        PH_ZRUN  = 7'b0100000,
        PH_FILL  = 7'b1000000
    } phase_t;

    // effective configuration seen by the parser
    typedef struct packed {
        logic [5:0]        size;
        logic [2:0]        bits;
        logic signed [5:0] special;
    } cfg_t;

    typedef struct packed {
        logic       last;
        logic [4:0] single_code;
        logic       single_mode;
        logic [4:0] entry_length;
        logic [4:0] entry_index;
    } result_t;

endpackage

// ===== design/clld_parse.sv =====
// ----------------------------------------------------------------------------
// clld_parse
// Bit-serial field parser and zero fill sequencer, at most one entry per cycle while out_space is high.
// ----------------------------------------------------------------------------
module clld_parse (
    input  logic             aclk,
    input  logic             aresetn,
    input  clld_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_bit,
    input  logic             in_start,
    input  logic             out_space,
    output logic             res_valid,
    output clld_pkg::result_t res
);
    import clld_pkg::*;

    phase_t     phase_reg, phase_next;
    phase_t     after_reg, after_next;
    logic [4:0] fs_reg, fs_next;
    logic [2:0] br_reg, br_next;
    logic [5:0] ni_reg, ni_next;
    logic [5:0] ec_reg, ec_next;
    logic [4:0] acc_reg, acc_next;
    logic [3:0] ones_reg, ones_next;
    logic [5:0] end_reg, end_next;
    logic       fsingle_reg, fsingle_next;
    logic [4:0] fcode_reg, fcode_next;

    phase_t     st_phase;
    logic [4:0] st_fs;
    logic [2:0] st_br;
    logic [5:0] st_ni;
    logic [5:0] st_ec;
    logic [4:0] st_acc;
    logic [3:0] st_ones;
    logic [4:0] shifted;
    logic [2:0] br_dec;
    logic       fdone;
    logic [5:0] ni_plus;
    logic [5:0] ni_reg_plus;
    logic [5:0] zr_sum;
    logic [5:0] zr_end;
    logic       do_finish;
    logic [4:0] fin_len;
    logic       accept;

    assign in_ready = (phase_reg != PH_FILL) && out_space;
    assign accept   = in_valid && in_ready;

    always_comb begin
        phase_next   = phase_reg;
        after_next   = after_reg;
        fs_next      = fs_reg;
        br_next      = br_reg;
        ni_next      = ni_reg;
        ec_next      = ec_reg;
        acc_next     = acc_reg;
        ones_next    = ones_reg;
        end_next     = end_reg;
        fsingle_next = fsingle_reg;
        fcode_next   = fcode_reg;
        res_valid    = 1'b0;
        res          = '0;
        do_finish    = 1'b0;
        fin_len      = '0;

        st_phase = in_start ? PH_COUNT : phase_reg;
        st_fs    = in_start ? 5'd0 : fs_reg;
        st_br    = in_start ? cfg.bits : br_reg;
        st_ni    = in_start ? 6'd0 : ni_reg;
        st_ec    = in_start ? 6'd0 : ec_reg;
        st_acc   = in_start ? 5'd0 : acc_reg;
        st_ones  = in_start ? 4'd0 : ones_reg;

        shifted     = {st_fs[3:0], in_bit};
        br_dec      = (st_br != 3'd0) ? st_br - 3'd1 : 3'd0;
        fdone       = (br_dec == 3'd0);
        ni_plus     = st_ni + 6'd1;
        ni_reg_plus = ni_reg + 6'd1;
        zr_sum      = st_ni + {4'd0, shifted[1:0]};
        zr_end      = (zr_sum > cfg.size) ? cfg.size : zr_sum;
        if (zr_end >= st_ec) begin
            zr_end = cfg.size;
        end

        if (phase_reg == PH_FILL) begin
            if (out_space) begin
                res_valid        = 1'b1;
                res.entry_index  = ni_reg[4:0];
                res.single_mode  = fsingle_reg;
                res.single_code  = fcode_reg;
                res.last         = (ni_reg_plus >= cfg.size);
                ni_next          = ni_reg_plus;
                if (ni_reg_plus == end_reg) begin
                    phase_next = after_reg;
                end
            end
        end else if (accept) begin
            phase_next = st_phase;
            fs_next    = st_fs;
            br_next    = st_br;
            ni_next    = st_ni;
            ec_next    = st_ec;
            acc_next   = st_acc;
            ones_next  = st_ones;
            case (st_phase)
                PH_COUNT: begin
                    fs_next = shifted;
                    br_next = br_dec;
                    if (fdone) begin
                        if (shifted == 5'd0) begin
                            phase_next = PH_CODE;
                            fs_next    = 5'd0;
                            br_next    = cfg.bits;
                        end else begin
                            ec_next    = ({1'b0, shifted} > cfg.size) ? cfg.size
                                                                      : {1'b0, shifted};
                            phase_next = PH_LEN;
                            fs_next    = 5'd0;
                            br_next    = LEN_BITS;
                        end
                    end
                end
                PH_CODE: begin
                    fs_next = shifted;
                    br_next = br_dec;
                    if (fdone) begin
                        phase_next   = PH_FILL;
                        end_next     = cfg.size;
                        after_next   = PH_IDLE;
                        fsingle_next = 1'b1;
                        fcode_next   = shifted;
                    end
                end
                PH_LEN: begin
                    fs_next = shifted;
                    br_next = br_dec;
                    if (fdone) begin
                        acc_next  = {2'd0, shifted[2:0]};
                        ones_next = 4'd0;
                        if (shifted[2:0] == LEN_ESCAPE) begin
                            phase_next = PH_UNARY;
                        end else begin
                            do_finish = 1'b1;
                            fin_len   = {2'd0, shifted[2:0]};
                        end
                    end
                end
                PH_UNARY: begin
                    if (st_ones < UNARY_MAX && in_bit) begin
                        ones_next = st_ones + 4'd1;
                        acc_next  = st_acc + 5'd1;
                    end else begin
                        do_finish = 1'b1;
                        fin_len   = st_acc;
                    end
                end
                PH_ZRUN: begin
                    fs_next = shifted;
                    br_next = br_dec;
                    if (fdone) begin
                        fs_next = 5'd0;
                        br_next = LEN_BITS;
                        if (zr_end > st_ni) begin
                            phase_next   = PH_FILL;
                            end_next     = zr_end;
                            after_next   = (zr_end == cfg.size) ? PH_IDLE : PH_LEN;
                            fsingle_next = 1'b0;
                            fcode_next   = 5'd0;
                        end else begin
                            phase_next = PH_LEN;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_finish) begin
                res_valid        = 1'b1;
                res.entry_index  = st_ni[4:0];
                res.entry_length = fin_len;
                res.last         = (ni_plus >= cfg.size);
                ni_next          = ni_plus;
                if (ni_plus >= cfg.size) begin
                    phase_next = PH_IDLE;
                end else if (!cfg.special[5] && ni_plus == cfg.special) begin
                    phase_next = PH_ZRUN;
                    fs_next    = 5'd0;
                    br_next    = ZRUN_BITS;
                end else if (ni_plus >= st_ec) begin
                    phase_next   = PH_FILL;
                    end_next     = cfg.size;
                    after_next   = PH_IDLE;
                    fsingle_next = 1'b0;
                    fcode_next   = 5'd0;
                end else begin
                    phase_next = PH_LEN;
                    fs_next    = 5'd0;
                    br_next    = LEN_BITS;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            after_reg <= PH_IDLE;
            fs_reg    <= '0;
            br_reg    <= '0;
            ni_reg    <= '0;
            ec_reg    <= '0;
            acc_reg   <= '0;
            ones_reg  <= '0;
            end_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            after_reg <= after_next;
            fs_reg    <= fs_next;
            br_reg    <= br_next;
            ni_reg    <= ni_next;
            ec_reg    <= ec_next;
            acc_reg   <= acc_next;
            ones_reg  <= ones_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        fsingle_reg <= fsingle_next;
        fcode_reg   <= fcode_next;
    end

endmodule

// ===== design/clld_out_buf.sv =====
// ----------------------------------------------------------------------------
// clld_out_buf
// Two-entry output buffer between the parser and the result stream.
// ----------------------------------------------------------------------------
module clld_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  clld_pkg::result_t push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output clld_pkg::result_t m_data
);
    import clld_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    result_t    mem_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       pop;

    assign space   = (count_reg != DEPTH);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/code_length_list_decoder.sv =====
// ----------------------------------------------------------------------------
// code_length_list_decoder
// Decodes a list of code lengths from a bit stream, one entry per beat out.
// ----------------------------------------------------------------------------
// The block takes one stream bit per cycle and, once a length field is
// complete, writes the table entry into a two-entry output buffer in the same
// cycle, so the buffer registers hold a result once the bit that ends it is
// taken. Zero fill runs (constant code tables, zero-run fields, the tail after
// the last coded entry) go out one entry per cycle from the fill sequencer,
// while the buffer has space, and the input is held off until the run is done.
// Input is also held while the output buffer is full.
module code_length_list_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] bit_value
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] entry_index, [9:5] entry_length,
                                   // [14:10] single_code
    output logic        m_tuser,   // [0] single_mode
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_wdata
);
    import clld_pkg::*;

    logic [5:0] table_size_reg;
    logic [2:0] count_bits_reg;
    logic [5:0] special_index_reg;
    cfg_t       cfg;
    logic       space;
    logic       res_valid;
    result_t    res;
    result_t    out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg    <= 6'd19;
            count_bits_reg    <= 3'd5;
            special_index_reg <= 6'd3;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TABLE_SIZE:    table_size_reg    <= cfg_wdata;
                REG_COUNT_BITS:    count_bits_reg    <= cfg_wdata[2:0];
                REG_SPECIAL_INDEX: special_index_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.size = table_size_reg;
        if (table_size_reg == 6'd0) begin
            cfg.size = 6'd1;
        end else if (table_size_reg > SIZE_LIMIT) begin
            cfg.size = SIZE_LIMIT;
        end
        cfg.bits = count_bits_reg;
        if (count_bits_reg == 3'd0) begin
            cfg.bits = 3'd1;
        end else if (count_bits_reg > MAX_FIELD_BITS) begin
            cfg.bits = MAX_FIELD_BITS;
        end
        cfg.special = special_index_reg;
    end

    clld_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_bit    (s_tdata[0]),
        .in_start  (s_tuser),
        .out_space (space),
        .res_valid (res_valid),
        .res       (res)
    );

    clld_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = {1'b0, out_data.single_code, out_data.entry_length,
                      out_data.entry_index};
    assign m_tuser = out_data.single_mode;
    assign m_tlast = out_data.last;

endmodule

// ===== design/clld_checker.sv =====
// ----------------------------------------------------------------------------
// clld_sva
// Port-level checks on the result stream of the code length list decoder.
// ----------------------------------------------------------------------------
module clld_sva (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // longest length is escape plus full unary run
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:5] <= 5'd20)
        else $error("entry length out of range");

    // constant code tables carry zero lengths
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[9:5] == 5'd0)
        else $error("nonzero length in single mode");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[14:10] == 5'd0)
        else $error("code set outside single mode");

endmodule

bind code_length_list_decoder clld_sva u_clld_sva (.*);

// ===== test/clld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clld_checker
// Watches the stream, register and entry channels of the code length list
// decoder, predicts every table entry from the accepted stream bits and
// compares each entry beat field by field, in order.
// ----------------------------------------------------------------------------
module clld_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] bit_value
    input  logic        s_tuser,   // [0] start_req
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [4:0] entry_index, [9:5] entry_length,
                                   // [14:10] single_code
    input  logic        m_tuser,   // [0] single_mode
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_wdata,
    output int          mismatches,
    output int          outstanding
);

    import clld_pkg::*;

    logic [5:0]        size_reg;
    logic [2:0]        width_reg;
    logic signed [5:0] zrun_at;

    phase_t     phase;
    logic [4:0] shreg;
    logic [2:0] bits_left;
    int         idx;
    int         count;
    logic [4:0] len_acc;
    logic [3:0] ones;

    result_t entry_q[$];
    int      miss_cnt = 0;
    int      beat_no = 0;

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic int size_eff();
        int s;
        s = size_reg;
        if (s < 1) s = 1;
        if (s > SIZE_LIMIT) s = SIZE_LIMIT;
        return s;
    endfunction

    function automatic int width_eff();
        int b;
        b = width_reg;
        if (b < 1) b = 1;
        if (b > MAX_FIELD_BITS) b = MAX_FIELD_BITS;
        return b;
    endfunction

    function automatic void push_entry(logic [4:0] len, logic single, logic [4:0] code);
        result_t r;
        r.entry_index  = idx[4:0];
        r.entry_length = len;
        r.single_mode  = single;
        r.single_code  = code;
        r.last         = (idx + 1 >= size_eff());
        entry_q.push_back(r);
        idx++;
    endfunction

    function automatic void zero_fill(logic single, logic [4:0] code);
        while (idx < size_eff()) push_entry(5'd0, single, code);
        phase = PH_IDLE;
    endfunction

    function automatic logic shift_bit(logic b);
        shreg = {shreg[3:0], b};
        if (bits_left != 3'd0) bits_left--;
        return bits_left == 3'd0;
    endfunction

    function automatic void open_length();
        phase = PH_LEN;
        shreg = '0;
        bits_left = LEN_BITS;
    endfunction

    function automatic void close_entry();
        push_entry(len_acc, 1'b0, 5'd0);
        if (idx >= size_eff()) begin
            phase = PH_IDLE;
        end else if (idx == int'(zrun_at)) begin
            phase = PH_ZRUN;
            shreg = '0;
            bits_left = ZRUN_BITS;
        end else if (idx >= count) begin
            zero_fill(1'b0, 5'd0);
        end else begin
            open_length();
        end
    endfunction

    function automatic void decode_bit(logic b, logic start);
        int c;
        int run;
        if (start) begin
            phase = PH_COUNT;
            shreg = '0;
            bits_left = 3'(width_eff());
            idx = 0;
            count = 0;
            len_acc = '0;
            ones = '0;
        end
        case (phase)
            PH_COUNT: begin
                if (shift_bit(b)) begin
                    c = shreg;
                    if (c == 0) begin
                        phase = PH_CODE;
                        shreg = '0;
                        bits_left = 3'(width_eff());
                    end else begin
                        if (c > size_eff()) c = size_eff();
                        count = c;
                        open_length();
                    end
                end
            end
            PH_CODE: begin
                if (shift_bit(b)) zero_fill(1'b1, shreg);
            end
            PH_LEN: begin
                if (shift_bit(b)) begin
                    len_acc = {2'b00, shreg[2:0]};
                    ones = '0;
                    if (shreg[2:0] == LEN_ESCAPE) phase = PH_UNARY;
                    else close_entry();
                end
            end
            PH_UNARY: begin
                if (ones < UNARY_MAX && b) begin
                    ones++;
                    len_acc++;
                end else begin
                    close_entry();
                end
            end
            PH_ZRUN: begin
                if (shift_bit(b)) begin
                    run = shreg[1:0];
                    while (run > 0 && idx < size_eff()) begin
                        push_entry(5'd0, 1'b0, 5'd0);
                        run--;
                    end
                    if (idx >= count || idx >= size_eff()) zero_fill(1'b0, 5'd0);
                    else open_length();
                end
            end
            default: phase = PH_IDLE;
        endcase
    endfunction

    function automatic void note(string what, int want, int got);
        if (miss_cnt < 10)
            $display("entry beat %0d: %s expected %0d, got %0d", beat_no, what, want, got);
        miss_cnt++;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            size_reg = 6'd19;
            width_reg = 3'd5;
            zrun_at = 6'sd3;
            phase = PH_IDLE;
            shreg = '0;
            bits_left = '0;
            idx = 0;
            count = 0;
            len_acc = '0;
            ones = '0;
            entry_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TABLE_SIZE:    size_reg = cfg_wdata;
                    REG_COUNT_BITS:    width_reg = cfg_wdata[2:0];
                    REG_SPECIAL_INDEX: zrun_at = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (entry_q.size() == 0) begin
                    note("no entry pending, entry_index", -1, m_tdata[4:0]);
                end else begin
                    want = entry_q.pop_front();
                    if (m_tdata[4:0] !== want.entry_index)
                        note("entry_index", want.entry_index, m_tdata[4:0]);
                    if (m_tdata[9:5] !== want.entry_length)
                        note("entry_length", want.entry_length, m_tdata[9:5]);
                    if (m_tuser !== want.single_mode)
                        note("single_mode", want.single_mode, m_tuser);
                    if (m_tdata[14:10] !== want.single_code)
                        note("single_code", want.single_code, m_tdata[14:10]);
                    if (m_tlast !== want.last)
                        note("last", want.last, m_tlast);
                end
                beat_no++;
            end
            if (s_tvalid && s_tready) decode_bit(s_tdata[0], s_tuser);
        end
        mismatches <= miss_cnt;
        outstanding <= entry_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the code length list decoder with hand-built and random code length
// streams under several register settings, with random gaps on both sides
// and one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

    import clld_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int BITS_PER_PHASE = 16;
    localparam int NUM_PHASES     = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_TABLE_SIZE;
    logic [5:0]  cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int cycle_cnt = 0;

    logic [1:0] stream_q[$];  // {start_req, bit_value}
    int gen_size;
    int gen_width;
    int gen_zrun;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit rx_hold = 1'b0;

    int phase_size[NUM_PHASES]  = '{19, 1, 8, 63, 0, 6, 32, 12};
    int phase_width[NUM_PHASES] = '{5, 1, 3, 7, 0, 4, 2, 5};
    int phase_zrun[NUM_PHASES]  = '{3, 0, 8, -1, 31, 5, 31, -32};

    code_length_list_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    clld_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : rx_side
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 10);
            if (rx_hold) begin
                rx_hold = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic write_reg(logic [1:0] index, logic [5:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic configure(int ts, int cb, int si);
        write_reg(REG_TABLE_SIZE, 6'(ts));
        write_reg(REG_COUNT_BITS, 6'(cb));
        write_reg(REG_SPECIAL_INDEX, 6'(si));
        cfg_wr_en <= 1'b0;
        gen_size = (ts < 1) ? 1 : ((ts > SIZE_LIMIT) ? int'(SIZE_LIMIT) : ts);
        gen_width = (cb < 1) ? 1 : ((cb > MAX_FIELD_BITS) ? int'(MAX_FIELD_BITS) : cb);
        gen_zrun = si;
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send(logic [1:0] item);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, item[0]};
        s_tuser <= item[1];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic play();
        while (stream_q.size() != 0) send(stream_q.pop_front());
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_field(logic [31:0] value, int width, bit opens);
        for (int i = width - 1; i >= 0; i--)
            stream_q.push_back({opens && (i == width - 1), value[i]});
    endtask

    // one code length list, well formed unless cut short
    task automatic gen_code_list(bit broken);
        int  base;
        int  maxc;
        int  hi;
        int  c;
        int  idx;
        int  v;
        int  k;
        int  r;
        bit  done;
        base = stream_q.size();
        maxc = (1 << gen_width) - 1;
        case ($urandom_range(0, 9))
            0: c = 0;
            1: c = $urandom_range(0, maxc);
            default: begin
                hi = (maxc < gen_size) ? maxc : gen_size;
                if (hi > 8) hi = 8;
                c = $urandom_range(1, hi);
            end
        endcase
        push_field(c, gen_width, 1'b1);
        if (c == 0) begin
            push_field($urandom_range(0, maxc), gen_width, 1'b0);
        end else begin
            if (c > gen_size) c = gen_size;
            idx = 0;
            done = 1'b0;
            while (!done) begin
                v = $urandom_range(0, 7);
                push_field(v, 3, 1'b0);
                if (v == LEN_ESCAPE) begin
                    k = ($urandom_range(0, 3) == 0) ? int'(UNARY_MAX)
                                                    : $urandom_range(0, UNARY_MAX - 1);
                    push_field('1, k, 1'b0);
                    push_field((k == UNARY_MAX) ? $urandom_range(0, 1) : 0, 1, 1'b0);
                end
                idx++;
                if (idx >= gen_size) begin
                    done = 1'b1;
                end else if (idx == gen_zrun) begin
                    r = $urandom_range(0, 3);
                    push_field(r, 2, 1'b0);
                    idx += r;
                    done = (idx >= c || idx >= gen_size);
                end else begin
                    done = (idx >= c);
                end
            end
        end
        if (broken && stream_q.size() - base > 1) begin
            k = $urandom_range(1, stream_q.size() - base - 1);
            while (stream_q.size() > base + k) stream_q.delete(stream_q.size() - 1);
        end
    endtask

    task automatic gen_random(int budget);
        logic [1:0] noise;
        while (stream_q.size() < budget) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 4)) begin
                        noise = {($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1))};
                        stream_q.push_back(noise);
                    end
                end
                1: gen_code_list(1'b1);
                default: gen_code_list(1'b0);
            endcase
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // three entries, one-bit fields, zero run after the first entry
        configure(3, 1, 1);
        push_field(1, 1, 1'b0);          // stray bit while idle
        push_field(1, 1, 1'b1);          // count of one, then abandoned by a new start
        push_field(0, 1, 1'b1);          // zero count: constant code table
        push_field(1, 1, 1'b0);
        push_field(1, 1, 1'b1);          // one coded entry
        push_field(LEN_ESCAPE, 3, 1'b0);
        push_field('1, UNARY_MAX, 1'b0); // longest unary run
        push_field(1, 1, 1'b0);          // terminator taken as is
        push_field(3, 2, 1'b0);          // zero run past the end
        play();

        for (int p = 0; p < NUM_PHASES; p++) begin
            configure(phase_size[p], phase_width[p], phase_zrun[p]);
            if (p == 0) begin
                tx_quiet = 1'b1;
                rx_hold = 1'b1;
            end
            gen_random(BITS_PER_PHASE);
            play();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
